// File: rtl/rbo_pkg.sv
`default_nettype none

package rbo_pkg;

    // Default ring depth in bytes.
    localparam int DEPTH_DEF = 256;

    // Width of the byte and of the reported count.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // Result flags handed from the index control to the output stage.
    typedef struct packed {
        logic [COUNT_W-1:0] fill_count;
        logic               pop_was_empty;
        logic               oldest_dropped;
        logic               pop_hit;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/rbo_store.sv
`default_nettype none

module rbo_store #(
    parameter int DEPTH = rbo_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_addr,
    input  wire logic [rbo_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [IDX_W-1:0]         rd_addr,
    output logic      [rbo_pkg::BYTE_W-1:0] rd_data
);

    logic [rbo_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/rbo_ctrl.sv
`default_nettype none

module rbo_ctrl #(
    parameter int DEPTH = rbo_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [1:0]       req_type,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    output rbo_pkg::res_t         res
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] count_reg,  count_next;
    logic             is_push;
    logic             hit;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i);
        return (i == LAST) ? '0 : i + IDX_W'(1);
    endfunction

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        is_push     = 1'b0;
        hit         = 1'b0;
        res         = '0;
        case (rbo_pkg::req_t'(req_type))
            rbo_pkg::REQ_PUSH:
            begin
                is_push     = 1'b1;
                wr_idx_next = step_idx(wr_idx_reg);
                if (count_reg == LAST)
                begin
                    rd_idx_next        = step_idx(rd_idx_reg);
                    res.oldest_dropped = 1'b1;
                end
                else
                begin
                    count_next = count_reg + IDX_W'(1);
                end
            end
            rbo_pkg::REQ_POP:
            begin
                if (count_reg != '0)
                begin
                    hit         = 1'b1;
                    rd_idx_next = step_idx(rd_idx_reg);
                    count_next  = count_reg - IDX_W'(1);
                end
                else
                begin
                    res.pop_was_empty = 1'b1;
                end
            end
            rbo_pkg::REQ_CLEAR:
            begin
                wr_idx_next = '0;
                rd_idx_next = '0;
                count_next  = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        res.pop_hit    = hit;
        res.fill_count = rbo_pkg::COUNT_W'(count_next);
    end

    assign wr_en   = accept & is_push;
    assign wr_addr = wr_idx_reg;
    assign rd_en   = accept & hit;
    assign rd_addr = rd_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rx_byte_ring_buffer_overwrite.sv
// A push, clear or unused request, or a pop of an empty ring, gives its result beat in the cycle
// after it is accepted; a pop that finds data gives its beat once the memory read returns through
// the pending flag. Throughput: one request per cycle while the output register is free, except
// that a pop with data holds the input while the byte store's single read port returns the byte.
// Reset: indices and count clear at once; the byte store is not cleared and needs no pass.
`default_nettype none

module rx_byte_ring_buffer_overwrite #(
    parameter int DEPTH = rbo_pkg::DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pop_data,
    output logic             pop_was_empty,
    output logic             oldest_dropped,
    output logic [7:0]       fill_count
);

    localparam int IDX_W = $clog2(DEPTH);

    // A request is taken when no pop read is in flight and the output register is
    // either empty or being emptied in this same cycle.
    logic accept;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    rbo_pkg::res_t    res;

    logic pend_reg;
    logic out_valid_reg;

    assign in_ready  = !pend_reg && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    rbo_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    rbo_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control: a pop with data parks in the pending flag for one cycle while the
    // memory read completes; every other request goes straight to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= accept && res.pop_hit;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (accept)
            begin
                out_valid_reg <= !res.pop_hit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: the flags and count are captured at acceptance, and the popped byte
    // replaces the zero data when the read returns, while the pending flag is set.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_data       <= '0;
            pop_was_empty  <= res.pop_was_empty;
            oldest_dropped <= res.oldest_dropped;
            fill_count     <= res.fill_count;
        end
        else if (pend_reg)
        begin
            pop_data <= rd_data;
        end
    end

endmodule

`default_nettype wire
